### hdl/ede_pkg.sv
package ede_pkg;

    localparam int MAX_LEN = 64;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CHAR_W  = 8;
    localparam int DIST_W  = 7;
    localparam int ERR_W   = 2;

    typedef enum logic [1:0] {
        FN_CLEAR  = 2'd0,
        FN_FIRST  = 2'd1,
        FN_SECOND = 2'd2,
        FN_REPORT = 2'd3
    } t_func;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK   = 2'd0,
        ERR_FULL = 2'd1,
        ERR_LATE = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RPT
    } t_state;

endpackage

### hdl/edit_distance_engine.sv
// channel   direction   handshake                   payload
// in        sink        i_in_valid / o_in_ready     i_func, i_char_value
// out       source      o_out_valid / i_out_ready   o_distance, o_error_code
//
// clear, first-string and non-walking second-string items are handled in the idle state
// a report reads the row memory, then loads the output register
// a row walk reads one cell and writes one back per cycle, the read running
//   one cell ahead of the write
// i_rst_n clears the lengths, the error and the output valid, not the memories
// a report waits in place while the output still holds an untaken item
module edit_distance_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_func,
    input  logic [ede_pkg::CHAR_W-1:0]  i_char_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [ede_pkg::DIST_W-1:0]  o_distance,
    output logic [ede_pkg::ERR_W-1:0]   o_error_code
);

    // storage
    logic [ede_pkg::CHAR_W-1:0] mem_fs [ede_pkg::MAX_LEN];
    logic [ede_pkg::DIST_W-1:0] mem_dp [ede_pkg::MAX_LEN];  // cells 1..MAX_LEN

    ede_pkg::t_state             r_state, n_state;
    logic [ede_pkg::LEN_W-1:0]   r_first_len;
    logic [ede_pkg::LEN_W-1:0]   r_second_len;   // also cell 0 of the row
    ede_pkg::t_err               r_err;
    logic [ede_pkg::LEN_W-1:0]   r_idx;
    logic                        r_pend;
    logic [ede_pkg::ADDR_W-1:0]  r_wr_addr;
    logic [ede_pkg::DIST_W-1:0]  r_diag;
    logic [ede_pkg::DIST_W-1:0]  r_left;
    logic [ede_pkg::CHAR_W-1:0]  r_ch;
    logic [ede_pkg::CHAR_W-1:0]  r_fs_q;
    logic [ede_pkg::DIST_W-1:0]  r_dp_q;
    logic                        r_out_valid;
    logic [ede_pkg::DIST_W-1:0]  r_distance;
    logic [ede_pkg::ERR_W-1:0]   r_error_code;

    ede_pkg::t_func              in_func;
    logic                        in_acc;
    logic                        out_free;
    logic                        rd_en;
    logic                        fs_rd_en;
    logic [ede_pkg::ADDR_W-1:0]  rd_addr;
    logic                        walk_issue;
    logic                        walk_last;
    logic                        sec_full;
    logic                        first_ok;
    logic [ede_pkg::DIST_W-1:0]  up;
    logic [ede_pkg::DIST_W-1:0]  min_ul;
    logic [ede_pkg::DIST_W-1:0]  min3;
    logic [ede_pkg::DIST_W-1:0]  dp_cell;
    logic [ede_pkg::DIST_W-1:0]  rpt_value;

    assign in_func    = ede_pkg::t_func'(i_func);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign sec_full   = (r_second_len >= ede_pkg::LEN_W'(ede_pkg::MAX_LEN));
    assign first_ok   = (r_second_len == '0) &&
                        (r_first_len < ede_pkg::LEN_W'(ede_pkg::MAX_LEN));
    assign walk_issue = (r_idx < r_first_len);
    assign walk_last  = r_pend && !walk_issue;

    // one dp cell per cycle
    assign up      = r_dp_q;
    assign min_ul  = (up < r_left) ? up : r_left;
    assign min3    = (min_ul < r_diag) ? min_ul : r_diag;
    assign dp_cell = (r_fs_q == r_ch) ? r_diag : min3 + ede_pkg::DIST_W'(1);

    assign rpt_value = (r_first_len == '0) ? ede_pkg::DIST_W'(r_second_len) : r_dp_q;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ede_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (in_func == ede_pkg::FN_REPORT) begin
                        n_state = ede_pkg::ST_RPT;
                    end else if (in_func == ede_pkg::FN_SECOND && !sec_full &&
                                 r_first_len != '0) begin
                        n_state = ede_pkg::ST_WALK;
                    end
                end
            end
            ede_pkg::ST_WALK: begin
                if (walk_last) begin
                    n_state = ede_pkg::ST_IDLE;
                end
            end
            ede_pkg::ST_RPT: begin
                if (out_free) begin
                    n_state = ede_pkg::ST_IDLE;
                end
            end
            default: n_state = ede_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        rd_en      = 1'b0;
        fs_rd_en   = 1'b0;
        rd_addr    = r_idx[ede_pkg::ADDR_W-1:0];
        unique case (r_state)
            ede_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                // report reads cell first_length, stored at first_length - 1
                rd_addr    = ede_pkg::ADDR_W'(r_first_len - ede_pkg::LEN_W'(1));
                rd_en      = in_acc && in_func == ede_pkg::FN_REPORT &&
                             r_first_len != '0;
            end
            ede_pkg::ST_WALK: begin
                rd_en    = walk_issue;
                fs_rd_en = walk_issue;
            end
            ede_pkg::ST_RPT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_dp_q <= mem_dp[rd_addr];
        end
        if (fs_rd_en) begin
            r_fs_q <= mem_fs[rd_addr];
        end
        if (r_state == ede_pkg::ST_WALK && r_pend) begin
            mem_dp[r_wr_addr] <= dp_cell;
        end else if (in_acc && in_func == ede_pkg::FN_FIRST && first_ok) begin
            mem_dp[r_first_len[ede_pkg::ADDR_W-1:0]] <=
                ede_pkg::DIST_W'(r_first_len + ede_pkg::LEN_W'(1));
        end
        if (in_acc && in_func == ede_pkg::FN_FIRST && first_ok) begin
            mem_fs[r_first_len[ede_pkg::ADDR_W-1:0]] <= i_char_value;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ede_pkg::ST_IDLE;
            r_first_len  <= '0;
            r_second_len <= '0;
            r_err        <= ede_pkg::ERR_OK;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                case (in_func)
                    ede_pkg::FN_CLEAR: begin
                        r_first_len  <= '0;
                        r_second_len <= '0;
                        r_err        <= ede_pkg::ERR_OK;
                    end
                    ede_pkg::FN_FIRST: begin
                        if (r_second_len != '0) begin
                            if (r_err == ede_pkg::ERR_OK) r_err <= ede_pkg::ERR_LATE;
                        end else if (!first_ok) begin
                            if (r_err == ede_pkg::ERR_OK) r_err <= ede_pkg::ERR_FULL;
                        end else begin
                            r_first_len <= r_first_len + ede_pkg::LEN_W'(1);
                        end
                    end
                    ede_pkg::FN_SECOND: begin
                        if (sec_full) begin
                            if (r_err == ede_pkg::ERR_OK) r_err <= ede_pkg::ERR_FULL;
                        end else begin
                            r_second_len <= r_second_len + ede_pkg::LEN_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (in_acc && in_func == ede_pkg::FN_SECOND) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
            end else if (r_state == ede_pkg::ST_WALK) begin
                if (walk_issue) begin
                    r_idx <= r_idx + ede_pkg::LEN_W'(1);
                end
                r_pend <= walk_issue;
            end
            if (r_state == ede_pkg::ST_RPT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk and output payload
    always_ff @(posedge i_clk) begin
        if (in_acc && in_func == ede_pkg::FN_SECOND) begin
            r_diag <= ede_pkg::DIST_W'(r_second_len);
            r_left <= ede_pkg::DIST_W'(r_second_len + ede_pkg::LEN_W'(1));
            r_ch   <= i_char_value;
        end else if (r_state == ede_pkg::ST_WALK && r_pend) begin
            r_diag <= up;
            r_left <= dp_cell;
        end
        r_wr_addr <= r_idx[ede_pkg::ADDR_W-1:0];
        if (r_state == ede_pkg::ST_RPT && out_free) begin
            r_distance   <= rpt_value;
            r_error_code <= r_err;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_distance   = r_distance;
    assign o_error_code = r_error_code;

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ede_pkg::ST_WALK |-> (r_idx <= r_first_len && r_first_len != '0))
        else $error("row walk index beyond first length");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_first_len <= ede_pkg::LEN_W'(ede_pkg::MAX_LEN)) &&
        (r_second_len <= ede_pkg::LEN_W'(ede_pkg::MAX_LEN)))
        else $error("string length beyond limit");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ede_pkg::ERR_OK && !(in_acc && in_func == ede_pkg::FN_CLEAR))
        |=> r_err == $past(r_err))
        else $error("sticky error changed without clear");

    a_first_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_func == ede_pkg::FN_FIRST && r_second_len != '0)
        |=> $stable(r_first_len))
        else $error("first string grew after second string began");

endmodule

### sim/edit_distance_engine_tb.sv
module edit_distance_engine_tb;

    localparam int ITEMS      = 1050;
    localparam int QUIET_N    = 150;
    localparam int TAIL_WAIT  = ede_pkg::MAX_LEN + 16;
    localparam int DIST_LIMIT = (1 << ede_pkg::DIST_W) - 1;

    typedef struct {
        ede_pkg::t_func             func;
        logic [ede_pkg::CHAR_W-1:0] ch;
        bit                         drain;
    } t_edit_req;

    typedef struct {
        logic [ede_pkg::DIST_W-1:0] distance;
        ede_pkg::t_err              err;
    } t_dist_result;

    logic                       i_clk;
    logic                       i_rst_n      = 1'b0;
    logic                       i_in_valid   = 1'b0;
    logic                       o_in_ready;
    logic [1:0]                 i_func       = 2'd0;
    logic [ede_pkg::CHAR_W-1:0] i_char_value = '0;
    logic                       o_out_valid;
    logic                       i_out_ready  = 1'b0;
    logic [ede_pkg::DIST_W-1:0] o_distance;
    logic [ede_pkg::ERR_W-1:0]  o_error_code;

    t_edit_req    req_q[$];
    t_dist_result dist_q[$];

    // shadow copy of the engine state
    logic [ede_pkg::CHAR_W-1:0] first_bytes[ede_pkg::MAX_LEN];
    int                         row_cells[ede_pkg::MAX_LEN+1];
    int                         first_len  = 0;
    int                         second_len = 0;
    ede_pkg::t_err              sticky_err = ede_pkg::ERR_OK;

    int  n_reports  = 0;
    int  n_received = 0;
    int  n_fail     = 0;
    int  idle_left  = 0;
    int  stall_left = 0;
    bit  quiet      = 1'b0;
    ede_pkg::t_func cur_func;
    logic [ede_pkg::CHAR_W-1:0] cur_char;

    edit_distance_engine i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_char_value (i_char_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_distance   (o_distance),
        .o_error_code (o_error_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void note_error(ede_pkg::t_err code);
        if (sticky_err == ede_pkg::ERR_OK)
            sticky_err = code;
    endfunction

    function automatic void advance_distance_model(ede_pkg::t_func f,
                                                   logic [ede_pkg::CHAR_W-1:0] c);
        int diag, up, nxt, lo;
        t_dist_result res;
        case (f)
            ede_pkg::FN_CLEAR: begin
                first_len    = 0;
                second_len   = 0;
                sticky_err   = ede_pkg::ERR_OK;
                row_cells[0] = 0;
            end
            ede_pkg::FN_FIRST: begin
                if (second_len != 0)
                    note_error(ede_pkg::ERR_LATE);
                else if (first_len >= ede_pkg::MAX_LEN)
                    note_error(ede_pkg::ERR_FULL);
                else begin
                    first_bytes[first_len] = c;
                    first_len++;
                    row_cells[first_len] = first_len;
                end
            end
            ede_pkg::FN_SECOND: begin
                if (second_len >= ede_pkg::MAX_LEN)
                    note_error(ede_pkg::ERR_FULL);
                else begin
                    second_len++;
                    diag = row_cells[0];
                    row_cells[0] = second_len;
                    for (int i = 1; i <= first_len; i++) begin
                        up = row_cells[i];
                        if (first_bytes[i-1] == c)
                            nxt = diag;
                        else begin
                            lo = (up < row_cells[i-1]) ? up : row_cells[i-1];
                            lo = (lo < diag) ? lo : diag;
                            nxt = lo + 1;
                        end
                        diag = up;
                        row_cells[i] = nxt;
                    end
                end
            end
            default: begin
                nxt = row_cells[first_len];
                if (nxt > DIST_LIMIT)
                    nxt = DIST_LIMIT;
                res.distance = nxt[ede_pkg::DIST_W-1:0];
                res.err      = sticky_err;
                dist_q.push_back(res);
            end
        endcase
    endfunction

    function automatic void push_req(ede_pkg::t_func f, logic [ede_pkg::CHAR_W-1:0] c,
                                     bit hold);
        t_edit_req r;
        r.func  = f;
        r.ch    = c;
        r.drain = hold;
        req_q.push_back(r);
    endfunction

    // narrow picks from four bytes around base so that matches are frequent
    function automatic logic [ede_pkg::CHAR_W-1:0] pick_byte(bit narrow,
                                                             logic [ede_pkg::CHAR_W-1:0] base);
        if (narrow)
            return base ^ ede_pkg::CHAR_W'($urandom_range(0, 3));
        return ede_pkg::CHAR_W'($urandom_range(0, 255));
    endfunction

    // driver: predicts each item as it is accepted, then offers the next
    always @(posedge i_clk) begin : drive
        logic next_valid;
        t_edit_req r;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            idle_left = 0;
        end else begin
            next_valid = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                advance_distance_model(cur_func, cur_char);
                if (cur_func == ede_pkg::FN_REPORT)
                    n_reports++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (idle_left > 0)
                    idle_left--;
                else if (req_q.size() != 0 &&
                         !(req_q[0].drain && n_reports != n_received)) begin
                    r = req_q.pop_front();
                    cur_func = r.func;
                    cur_char = r.ch;
                    i_func       <= r.func;
                    i_char_value <= r.ch;
                    next_valid = 1'b1;
                    if (!quiet && $urandom_range(0, 4) == 0)
                        idle_left = $urandom_range(1, 4);
                end
            end
            i_in_valid <= next_valid;
            quiet      <= (req_q.size() < QUIET_N);
        end
    end

    // monitor: checks each taken result against the oldest report
    always @(posedge i_clk) begin : watch
        t_dist_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_received <= n_received + 1;
                if (dist_q.size() == 0) begin
                    $display("%0t: unexpected result: distance %0d error %0d",
                             $time, o_distance, o_error_code);
                    n_fail++;
                end else begin
                    want = dist_q.pop_front();
                    if (o_distance !== want.distance) begin
                        $display("%0t: distance expected %0d actual %0d",
                                 $time, want.distance, o_distance);
                        n_fail++;
                    end
                    if (o_error_code !== want.err) begin
                        $display("%0t: error_code expected %0d actual %0d",
                                 $time, want.err, o_error_code);
                        n_fail++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 4);
            end
        end
    end

    initial begin : stimulus
        int la, lb, kind;
        bit narrow;
        logic [ede_pkg::CHAR_W-1:0] base;

        // directed: empty strings, byte extremes, late first byte, empty first string
        push_req(ede_pkg::FN_CLEAR,  8'hFF, 1'b0);
        push_req(ede_pkg::FN_REPORT, 8'h00, 1'b0);
        push_req(ede_pkg::FN_FIRST,  8'h00, 1'b0);
        push_req(ede_pkg::FN_FIRST,  8'hFF, 1'b0);
        push_req(ede_pkg::FN_FIRST,  8'h00, 1'b0);
        push_req(ede_pkg::FN_REPORT, 8'hFF, 1'b0);
        push_req(ede_pkg::FN_SECOND, 8'hFF, 1'b0);
        push_req(ede_pkg::FN_SECOND, 8'h00, 1'b0);
        push_req(ede_pkg::FN_REPORT, 8'h00, 1'b0);
        push_req(ede_pkg::FN_FIRST,  8'h5A, 1'b0);
        push_req(ede_pkg::FN_SECOND, 8'hFF, 1'b0);
        push_req(ede_pkg::FN_REPORT, 8'h00, 1'b0);
        push_req(ede_pkg::FN_CLEAR,  8'h00, 1'b1);
        push_req(ede_pkg::FN_SECOND, 8'h80, 1'b0);
        push_req(ede_pkg::FN_SECOND, 8'h01, 1'b0);
        push_req(ede_pkg::FN_REPORT, 8'h00, 1'b0);
        push_req(ede_pkg::FN_FIRST,  8'h7F, 1'b0);
        push_req(ede_pkg::FN_REPORT, 8'h00, 1'b0);
        push_req(ede_pkg::FN_CLEAR,  8'h00, 1'b0);
        push_req(ede_pkg::FN_REPORT, 8'h00, 1'b0);

        // both strings overflow, then a late byte: the full error stays
        push_req(ede_pkg::FN_CLEAR, 8'h00, 1'b0);
        for (int k = 0; k <= ede_pkg::MAX_LEN; k++)
            push_req(ede_pkg::FN_FIRST, pick_byte(1'b0, 8'h00), 1'b0);
        push_req(ede_pkg::FN_REPORT, 8'h00, 1'b0);
        for (int k = 0; k <= ede_pkg::MAX_LEN; k++)
            push_req(ede_pkg::FN_SECOND, pick_byte(1'b0, 8'h00), 1'b0);
        push_req(ede_pkg::FN_FIRST,  8'h00, 1'b0);
        push_req(ede_pkg::FN_REPORT, 8'h00, 1'b0);

        // late byte first, then second string overflow: the late error stays
        push_req(ede_pkg::FN_CLEAR,  8'h00, 1'b1);
        push_req(ede_pkg::FN_SECOND, 8'h3C, 1'b0);
        push_req(ede_pkg::FN_FIRST,  8'hC3, 1'b0);
        for (int k = 0; k < ede_pkg::MAX_LEN; k++)
            push_req(ede_pkg::FN_SECOND, pick_byte(1'b0, 8'h00), 1'b0);
        push_req(ede_pkg::FN_REPORT, 8'h00, 1'b0);

        while (req_q.size() < ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // noise
                repeat ($urandom_range(1, 6))
                    push_req(ede_pkg::t_func'($urandom_range(0, 3)),
                             pick_byte(1'b0, 8'h00), 1'b0);
            end else begin
                narrow = ($urandom_range(0, 2) != 0);
                base   = pick_byte(1'b0, 8'h00);
                la = ($urandom_range(0, 11) == 0) ?
                     $urandom_range(50, ede_pkg::MAX_LEN + 2) : $urandom_range(0, 12);
                lb = ($urandom_range(0, 11) == 0) ?
                     $urandom_range(50, ede_pkg::MAX_LEN + 2) : $urandom_range(0, 12);
                push_req(ede_pkg::FN_CLEAR, pick_byte(1'b0, 8'h00),
                         ($urandom_range(0, 19) == 0));
                for (int k = 0; k < la; k++)
                    push_req(ede_pkg::FN_FIRST, pick_byte(narrow, base), 1'b0);
                if ($urandom_range(0, 2) == 0)
                    push_req(ede_pkg::FN_REPORT, pick_byte(1'b0, 8'h00), 1'b0);
                for (int k = 0; k < lb; k++) begin
                    push_req(ede_pkg::FN_SECOND, pick_byte(narrow, base), 1'b0);
                    if ($urandom_range(0, 5) == 0)
                        push_req(ede_pkg::FN_REPORT, pick_byte(1'b0, 8'h00), 1'b0);
                end
                if ($urandom_range(0, 4) == 0)
                    push_req(ede_pkg::FN_FIRST, pick_byte(narrow, base), 1'b0);
                push_req(ede_pkg::FN_REPORT, pick_byte(1'b0, 8'h00), 1'b0);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() != 0 || i_in_valid || n_received != n_reports)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (n_fail == 0 && dist_q.size() == 0)
            $display("edit_distance_engine_tb passed");
        else
            $display("edit_distance_engine_tb failed");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("edit_distance_engine_tb failed");
        $finish;
    end

endmodule
